[design/frs_pkg.sv]
// Shared types and constants for the ring FIFO with statistics.
package frs_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int WORD_WIDTH_DEFAULT = 32;

    localparam int CMD_W       = 2;
    localparam int ELEM_W      = 32;
    localparam int OCC_W       = 5;
    localparam int CNT_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_FIELD_W = ELEM_W + OCC_W + 1 + 4 * CNT_W + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One result as built by the control path; the word comes from the memory.
    typedef struct packed {
        t_status            status;
        logic               take;
        logic [OCC_W-1:0]   occupancy;
        logic               is_empty;
        logic [CNT_W-1:0]   enq_total;
        logic [CNT_W-1:0]   deq_total;
        logic [CNT_W-1:0]   enq_rejects;
        logic [CNT_W-1:0]   deq_rejects;
        logic [OCC_W-1:0]   peak;
    } t_result;

endpackage

[design/frs_mem.sv]
// Slot store: one write port and one registered read port.
module frs_mem #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WORD_WIDTH-1:0]    i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WORD_WIDTH-1:0]    o_rd_data
);

    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds between reads so a stalled result keeps its word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/frs_ctrl.sv]
// Pointer, status and statistics logic; drives the slot store ports.
module frs_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  frs_pkg::t_cmd            i_command,
    output logic                     o_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic                     o_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    output frs_pkg::t_result         o_res
);
    import frs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int LW = IW + 1;

    logic [LW-1:0]    r_wp, n_wp;
    logic [LW-1:0]    r_rp, n_rp;
    logic [LW-1:0]    r_peak, n_peak;
    logic [CNT_W-1:0] r_enq, n_enq;
    logic [CNT_W-1:0] r_deq, n_deq;
    logic [CNT_W-1:0] r_erej, n_erej;
    logic [CNT_W-1:0] r_drej, n_drej;
    t_result          r_res;

    logic [LW-1:0] level;
    logic [LW-1:0] level_inc;
    logic [LW-1:0] n_level;
    logic [31:0]   n_level_wide;
    logic [31:0]   n_peak_wide;
    t_status       status;
    logic          take;

    assign level     = r_wp - r_rp;
    assign level_inc = level + LW'(1);

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_peak  = r_peak;
        n_enq   = r_enq;
        n_deq   = r_deq;
        n_erej  = r_erej;
        n_drej  = r_drej;
        o_wr_en = 1'b0;
        o_rd_en = 1'b0;
        status  = ST_OK;
        take    = 1'b0;
        if (i_accept) begin
            unique case (i_command)
                CMD_ENQ: begin
                    if (level == LW'(DEPTH)) begin
                        status = ST_FULL;
                        n_erej = r_erej + CNT_W'(1);
                    end else begin
                        o_wr_en = 1'b1;
                        n_wp    = r_wp + LW'(1);
                        n_enq   = r_enq + CNT_W'(1);
                        if (level_inc > r_peak) begin
                            n_peak = level_inc;
                        end
                    end
                end
                CMD_DEQ: begin
                    if (level == '0) begin
                        status = ST_EMPTY;
                        n_drej = r_drej + CNT_W'(1);
                    end else begin
                        o_rd_en = 1'b1;
                        take    = 1'b1;
                        n_rp    = r_rp + LW'(1);
                        n_deq   = r_deq + CNT_W'(1);
                    end
                end
                CMD_CLEAR: begin
                    n_enq  = '0;
                    n_deq  = '0;
                    n_erej = '0;
                    n_drej = '0;
                    n_peak = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign n_level      = n_wp - n_rp;
    assign n_level_wide = 32'(n_level);
    assign n_peak_wide  = 32'(n_peak);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_peak <= '0;
            r_enq  <= '0;
            r_deq  <= '0;
            r_erej <= '0;
            r_drej <= '0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_peak <= n_peak;
            r_enq  <= n_enq;
            r_deq  <= n_deq;
            r_erej <= n_erej;
            r_drej <= n_drej;
        end
    end

    // Result snapshot taken in the accept cycle, lines up with the read data.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_res.status      <= status;
            r_res.take        <= take;
            r_res.occupancy   <= n_level_wide[OCC_W-1:0];
            r_res.is_empty    <= (n_level == '0);
            r_res.enq_total   <= n_enq;
            r_res.deq_total   <= n_deq;
            r_res.enq_rejects <= n_erej;
            r_res.deq_rejects <= n_drej;
            r_res.peak        <= n_peak_wide[OCC_W-1:0];
        end
    end

    assign o_wr_addr = r_wp[IW-1:0];
    assign o_rd_addr = r_rp[IW-1:0];
    assign o_res     = r_res;

endmodule

[design/fifo_ring_with_statistics_top.sv]
// Top level of the ring FIFO with statistics: stream ports and output register.
// A result is valid in the cycle after its command transaction.
// Throughput: one command per cycle; the pointer update and the registered slot
// store read set this, and a held result stalls only the input.
// Reset (synchronous, active low) clears pointers, counters, peak and the
// output valid; the slot store is not cleared and needs no clearing pass.
module fifo_ring_with_statistics_top #(
    parameter int DEPTH      = frs_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = frs_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // element_in[31:0]
    input  logic [frs_pkg::ELEM_W-1:0]       s_axis_tdata,
    // command[1:0]
    input  logic [frs_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // element_out[31:0], occupancy[36:32], is_empty[37], enqueue_total[69:38],
    // dequeue_total[101:70], enqueue_rejects[133:102], dequeue_rejects[165:134],
    // peak_occupancy[170:166], zero pad[175:171]
    output logic [frs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [frs_pkg::STATUS_W-1:0]     m_axis_tuser
);
    import frs_pkg::*;

    localparam int IW = $clog2(DEPTH);

    logic                  r_valid;
    logic                  accept;
    logic                  wr_en;
    logic                  rd_en;
    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         rd_addr;
    logic [63:0]           in_wide;
    logic [63:0]           rd_wide;
    logic [WORD_WIDTH-1:0] rd_data;
    logic [ELEM_W-1:0]     elem_out;
    t_result               res;

    // No transaction is taken while reset is held.
    assign s_axis_tready = i_rst_n && (!r_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    frs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (t_cmd'(s_axis_tuser)),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_res     (res)
    );

    assign in_wide = 64'(s_axis_tdata);

    frs_mem #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (in_wide[WORD_WIDTH-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_wide  = 64'(rd_data);
    assign elem_out = res.take ? rd_wide[ELEM_W-1:0] : '0;

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = res.status;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - OUT_FIELD_W)'(0),
        res.peak,
        res.deq_rejects,
        res.enq_rejects,
        res.deq_total,
        res.enq_total,
        res.is_empty,
        res.occupancy,
        elem_out
    };

    // Every accepted command yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("no result after accepted command");

    // A refused dequeue leaves the queue empty.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.status == ST_EMPTY) |-> res.is_empty)
        else $error("empty status with entries held");

    // A refused enqueue means the queue holds entries.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.status == ST_FULL) |-> (!res.is_empty && !res.take))
        else $error("full status on an empty queue");

endmodule

[bench/fifo_ring_with_statistics_top_test.sv]
// Stream-level test of the ring FIFO with statistics, checked against a predicted ring.
module fifo_ring_with_statistics_top_test;
    import frs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RING_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 6;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ELEM_W-1:0]   element;
        logic [OCC_W-1:0]    occupancy;
        logic                is_empty;
        logic [CNT_W-1:0]    enq_total;
        logic [CNT_W-1:0]    deq_total;
        logic [CNT_W-1:0]    enq_rejects;
        logic [CNT_W-1:0]    deq_rejects;
        logic [OCC_W-1:0]    peak;
    } t_ring_outcome;

    // Predicted ring plus the queue of outcomes still owed by the block.
    class ring_scoreboard;
        logic [ELEM_W-1:0] slots[RING_DEPTH];
        logic [OCC_W-1:0]  wr_ptr, rd_ptr, peak;
        logic [CNT_W-1:0]  enq_total, deq_total, enq_rejects, deq_rejects;
        t_ring_outcome     owed_q[$];
        int                errors;

        function new();
            wr_ptr = '0;
            rd_ptr = '0;
            peak = '0;
            enq_total = '0;
            deq_total = '0;
            enq_rejects = '0;
            deq_rejects = '0;
            errors = 0;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [ELEM_W-1:0] word);
            t_ring_outcome o;
            logic [OCC_W-1:0] level;
            level = wr_ptr - rd_ptr;
            o.status = ST_OK;
            o.element = '0;
            if (cmd == CMD_ENQ) begin
                if (level >= RING_DEPTH) begin
                    o.status = ST_FULL;
                    enq_rejects++;
                end else begin
                    slots[wr_ptr[3:0]] = word;
                    wr_ptr++;
                    enq_total++;
                    level = wr_ptr - rd_ptr;
                    if (level > peak) peak = level;
                end
            end else if (cmd == CMD_DEQ) begin
                if (level == 0) begin
                    o.status = ST_EMPTY;
                    deq_rejects++;
                end else begin
                    o.element = slots[rd_ptr[3:0]];
                    rd_ptr++;
                    deq_total++;
                end
            end else if (cmd == CMD_CLEAR) begin
                enq_total = '0;
                deq_total = '0;
                enq_rejects = '0;
                deq_rejects = '0;
                peak = '0;
            end
            level = wr_ptr - rd_ptr;
            o.occupancy = level;
            o.is_empty = (level == 0);
            o.enq_total = enq_total;
            o.deq_total = deq_total;
            o.enq_rejects = enq_rejects;
            o.deq_rejects = deq_rejects;
            o.peak = peak;
            owed_q.push_back(o);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data,
                                   logic [STATUS_W-1:0] user);
            t_ring_outcome o;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual tdata 0x%0h",
                         $time, data);
                return;
            end
            o = owed_q.pop_front();
            compare_field("status", CNT_W'(o.status), CNT_W'(user));
            compare_field("element_out", o.element, data[31:0]);
            compare_field("occupancy", CNT_W'(o.occupancy), CNT_W'(data[36:32]));
            compare_field("is_empty", CNT_W'(o.is_empty), CNT_W'(data[37]));
            compare_field("enqueue_total", o.enq_total, data[69:38]);
            compare_field("dequeue_total", o.deq_total, data[101:70]);
            compare_field("enqueue_rejects", o.enq_rejects, data[133:102]);
            compare_field("dequeue_rejects", o.deq_rejects, data[165:134]);
            compare_field("peak_occupancy", CNT_W'(o.peak), CNT_W'(data[170:166]));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [ELEM_W-1:0]      s_axis_tdata;   // element_in[31:0]
    logic [CMD_W-1:0]       s_axis_tuser;   // command[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // element_out, occupancy, is_empty, counters, peak
    logic [STATUS_W-1:0]    m_axis_tuser;   // status[1:0]

    ring_scoreboard sb;
    bit             calm;
    int unsigned    cycle_count;

    fifo_ring_with_statistics_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        sb = new();
        calm = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        m_axis_tready <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: values sampled here are the ones present at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ELEM_W-1:0] word);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_command(cmd, word);
    endtask

    function automatic logic [ELEM_W-1:0] pick_word();
        int r;
        r = $urandom_range(19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    initial begin
        bit fill_mode;
        int run_left;
        int r;
        logic [CMD_W-1:0] cmd;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dequeue on empty, unused code, extreme words, clear keeps contents
        send_command(CMD_DEQ, 32'h1234_5678);
        send_command(CMD_UNUSED, '1);
        send_command(CMD_ENQ, '0);
        send_command(CMD_ENQ, '1);
        send_command(CMD_CLEAR, 32'hA5A5_5A5A);
        send_command(CMD_DEQ, '0);
        send_command(CMD_DEQ, '0);
        send_command(CMD_DEQ, '1);
        // fill to the brim, then one refused enqueue
        for (int i = 0; i < RING_DEPTH; i++)
            send_command(CMD_ENQ, (i % 2) ? 32'h5555_AAAA : 32'hAAAA_5555);
        send_command(CMD_ENQ, 32'hDEAD_BEEF);

        // bursts that alternately fill and drain so both full and empty recur
        fill_mode = 1'b1;
        run_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 400 && n < 650);
            if (run_left == 0) begin
                fill_mode = ~fill_mode;
                run_left = $urandom_range(10, 45);
            end
            run_left--;
            r = $urandom_range(99);
            if (r < 3)
                cmd = CMD_CLEAR;
            else if (r < 5)
                cmd = CMD_UNUSED;
            else if ($urandom_range(99) < (fill_mode ? 75 : 25))
                cmd = CMD_ENQ;
            else
                cmd = CMD_DEQ;
            send_command(cmd, pick_word());
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
